// ===== rtl/core/greedy_cost_matrix_assigner_macros.svh =====
// assertion helpers shared by the core
`ifndef GREEDY_COST_MATRIX_ASSIGNER_MACROS_SVH
`define GREEDY_COST_MATRIX_ASSIGNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GCMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcma assertion failed");

// next-cycle implication, checked outside reset
`define GCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcma assertion failed");

`endif

// ===== rtl/core/gcma_pkg.sv =====
package gcma_pkg;

  // fixed field widths of the channels
  localparam int unsigned ActionW = 1;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CostW   = 16;
  localparam int unsigned SizeW   = 5;
  localparam int unsigned ModeW   = 1;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 5;

  // input actions
  localparam logic [ActionW-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ActionW-1:0] ACT_START = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SIZE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_MODE = 1'b1;

  // mode codes
  localparam logic [ModeW-1:0] MODE_ROWS = 1'b0;
  localparam logic [ModeW-1:0] MODE_COLS = 1'b1;

  // reset values
  localparam logic [SizeW-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/core/gcma_if.sv =====
// request channel: cost loads and run starts
interface gcma_in_if;
  import gcma_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [IndexW-1:0]  row_index;
  logic [IndexW-1:0]  col_index;
  logic [CostW-1:0]   cost;

  modport source (output valid, output action, output row_index, output col_index,
                  output cost, input ready);
  modport sink   (input valid, input action, input row_index, input col_index,
                  input cost, output ready);
endinterface

// result channel: one transfer per agent
interface gcma_out_if;
  import gcma_pkg::*;

  logic              valid;
  logic              ready;
  logic [IndexW-1:0] agent;
  logic [IndexW-1:0] choice;
  logic              last;

  modport source (output valid, output agent, output choice, output last, input ready);
  modport sink   (input valid, input agent, input choice, input last, output ready);
endinterface

// ===== rtl/core/greedy_cost_matrix_assigner.sv =====
// Greedy assignment over a square cost matrix.
// in_i carries two kinds of transfer. A load (action 0) writes one cost entry
// at row_index/col_index; indexes at or beyond MAX_N are
// dropped. A start (action 1) runs the greedy pass over n = min(size, MAX_N)
// agents: in agent order each agent takes its cheapest still-free choice,
// ties going to the lowest index. Mode 0 has rows picking columns, mode 1 has
// columns picking rows from the column's own entries.
// out_o gives one transfer per agent in agent order, last set on the final one.
// A start with size zero gives no result.
// Timing: every cost entry is read through the single read port of the cost
// RAM into one shared comparator, one entry per cycle while an agent is
// scanned, with a drain and an emit step between agents. in_i is
// not ready until the run has handed its last result to the output register.
// A stalled receiver holds the output register; the scan of the next agent
// goes on but its result waits until the register frees.
// Reset clears the control state and sets size to 16 and mode to 0; the cost
// RAM is not cleared and must be loaded before a run reads it.
// cfg_we_i writes register cfg_index_i (0 size, 1 mode) from cfg_data_i; the user writes
// it only while the block is idle, which the block itself does not enforce.
`include "greedy_cost_matrix_assigner_macros.svh"

module greedy_cost_matrix_assigner #(
  parameter int unsigned MAX_N     = 16,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gcma_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gcma_pkg::CfgDataW-1:0] cfg_data_i,
  gcma_in_if.sink                  in_i,
  gcma_out_if.source               out_o
);
  import gcma_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_N);
  localparam int unsigned NW    = $clog2(MAX_N + 1);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 2 ** AddrW;

  // configuration registers
  logic [SizeW-1:0] size_q;
  logic [ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
      mode_q <= MODE_ROWS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIZE: size_q <= cfg_data_i[SizeW-1:0];
        REG_MODE: mode_q <= cfg_data_i[ModeW-1:0];
        default:  ;
      endcase
    end
  end

  // effective agent count
  logic [NW-1:0] n_eff;
  assign n_eff = (32'(size_q) > MAX_N) ? NW'(MAX_N) : NW'(size_q);

  // sequencer and datapath state
  state_e              state_q, state_d;
  logic [IdxW-1:0]     a_q, a_d;
  logic [IdxW-1:0]     j_q, j_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_j_q, pend_j_d;
  logic                bv_q, bv_d;
  logic [COST_BITS-1:0] bc_q, bc_d;
  logic [IdxW-1:0]     best_q, best_d;
  logic [MAX_N-1:0]    used_q, used_d;
  logic                out_valid_q, out_valid_d;
  logic [IdxW-1:0]     out_agent_q, out_agent_d;
  logic [IdxW-1:0]     out_choice_q, out_choice_d;
  logic                out_last_q, out_last_d;

  // cost RAM
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [AddrW-1:0]     ram_raddr;
  logic [COST_BITS-1:0] ram_rdata;

  gcma_ram #(
    .Width (COST_BITS),
    .Depth (Depth)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (COST_BITS'(in_i.cost)),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_fire, out_fire, in_range, take, out_free;
  logic j_end, a_end;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_range   = (32'(in_i.row_index) < MAX_N) && (32'(in_i.col_index) < MAX_N);

  assign ram_we    = in_fire && (in_i.action == ACT_LOAD) && in_range;
  assign ram_waddr = {IdxW'(in_i.row_index), IdxW'(in_i.col_index)};
  assign ram_raddr = (mode_q == MODE_COLS) ? {j_q, a_q} : {a_q, j_q};

  // shared compare on the entry read last cycle
  assign take = pend_q && !used_q[pend_j_q] && (!bv_q || (ram_rdata < bc_q));

  assign j_end = ((NW'(j_q) + NW'(1)) == n_eff);
  assign a_end = ((NW'(a_q) + NW'(1)) == n_eff);

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    j_d          = j_q;
    pend_d       = 1'b0;
    pend_j_d     = j_q;
    bv_d         = bv_q;
    bc_d         = bc_q;
    best_d       = best_q;
    used_d       = used_q;
    out_valid_d  = out_fire ? 1'b0 : out_valid_q;
    out_agent_d  = out_agent_q;
    out_choice_d = out_choice_q;
    out_last_d   = out_last_q;

    if (take) begin
      bv_d   = 1'b1;
      bc_d   = ram_rdata;
      best_d = pend_j_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.action == ACT_START)) begin
          used_d = '0;
          a_d    = '0;
          j_d    = '0;
          bv_d   = 1'b0;
          if (n_eff != '0) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_d = 1'b1;
        if (j_end) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_agent_d      = a_q;
          out_choice_d     = best_q;
          out_last_d       = a_end;
          used_d[best_q]   = 1'b1;
          bv_d             = 1'b0;
          j_d              = '0;
          if (a_end) begin
            state_d = ST_IDLE;
          end else begin
            a_d     = a_q + IdxW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      bv_q        <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      a_q         <= a_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      bv_q        <= bv_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_j_q     <= pend_j_d;
    bc_q         <= bc_d;
    best_q       <= best_d;
    out_agent_q  <= out_agent_d;
    out_choice_q <= out_choice_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.agent  = IndexW'(out_agent_q);
  assign out_o.choice = IndexW'(out_choice_q);
  assign out_o.last   = out_last_q;

  // a new result is loaded only from the emit step
  `GCMA_ASSERT_SAME(a_emit_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_EMIT)
  // one choice is marked per agent already served
  `GCMA_ASSERT_SAME(a_used_count, clk_i, rst_ni, state_q == ST_SCAN,
                    $countones(used_q) == 32'(a_q))
  // a pending compare always follows an issued read
  `GCMA_ASSERT_NEXT(a_pend_after_scan, clk_i, rst_ni, state_q == ST_SCAN, pend_q)

endmodule

// ===== rtl/core/gcma_ram.sv =====
module gcma_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/greedy_cost_matrix_assigner_tb.sv =====
`timescale 1ns / 1ps

module greedy_cost_matrix_assigner_tb;
  import gcma_pkg::*;

  localparam int unsigned MaxN = 16;
  localparam int unsigned Tail = 300;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [IndexW-1:0]  row;
    logic [IndexW-1:0]  col;
    logic [CostW-1:0]   cost;
  } cost_req_t;

  typedef struct {
    logic [IndexW-1:0] agent;
    logic [IndexW-1:0] choice;
    logic              last;
  } pick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  gcma_in_if  req_bus ();
  gcma_out_if pick_bus ();

  greedy_cost_matrix_assigner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (req_bus),
    .out_o       (pick_bus)
  );

  // own copy of the block state
  logic [CostW-1:0] cost_model [MaxN][MaxN];
  bit               entry_written [MaxN][MaxN];
  logic [SizeW-1:0] cfg_size = SIZE_RESET;
  logic [ModeW-1:0] cfg_mode = MODE_ROWS;

  cost_req_t request_queue [$];
  pick_t     expected_picks [$];
  int        error_count = 0;
  int        item_count = 0;
  bit        req_fire = 1'b0;
  bit        idle_on = 1'b1;
  int        recv_stall_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int eff_size();
    return (cfg_size > MaxN) ? MaxN : int'(cfg_size);
  endfunction

  // agent a looks at choice j in its own row or column
  function automatic logic [CostW-1:0] pick_cost(int a, int j);
    return (cfg_mode == MODE_COLS) ? cost_model[j][a] : cost_model[a][j];
  endfunction

  // greedy pass: cheapest free choice per agent, strict compare keeps ties low
  task automatic predict_assignment();
    int n;
    int best;
    logic [CostW-1:0] best_cost;
    bit taken [MaxN];
    n = eff_size();
    taken = '{default: 1'b0};
    for (int a = 0; a < n; a++) begin
      best = 0;
      while (best < n && taken[best]) best++;
      best_cost = pick_cost(a, best);
      for (int j = 0; j < n; j++) begin
        if (!taken[j] && pick_cost(a, j) < best_cost) begin
          best_cost = pick_cost(a, j);
          best = j;
        end
      end
      taken[best] = 1'b1;
      expected_picks.push_back('{agent: IndexW'(a), choice: IndexW'(best),
                                 last: (a == n - 1)});
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // input side: track transfers and update the predicted state
  always @(posedge clk_i) begin
    req_fire = rst_ni && req_bus.valid && req_bus.ready;
    if (req_fire) begin
      void'(request_queue.pop_front());
      if (req_bus.action == ACT_LOAD) begin
        cost_model[req_bus.row_index][req_bus.col_index] = req_bus.cost;
      end else begin
        predict_assignment();
      end
    end
  end

  // output side: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && pick_bus.valid && pick_bus.ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("unexpected result, agent", pick_bus.agent, -1);
      end else begin
        want = expected_picks.pop_front();
        if (pick_bus.agent !== want.agent)
          report_mismatch("agent", pick_bus.agent, want.agent);
        if (pick_bus.choice !== want.choice)
          report_mismatch("choice", pick_bus.choice, want.choice);
        if (pick_bus.last !== want.last)
          report_mismatch("last", pick_bus.last, want.last);
      end
    end
  end

  // driver: offers the head of the queue, idles at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_fire) begin
      if (request_queue.size() != 0 && !(idle_on && $urandom_range(99) < 25)) begin
        req_bus.valid     <= 1'b1;
        req_bus.action    <= request_queue[0].action;
        req_bus.row_index <= request_queue[0].row;
        req_bus.col_index <= request_queue[0].col;
        req_bus.cost      <= request_queue[0].cost;
      end else begin
        req_bus.valid     <= 1'b0;
        req_bus.action    <= ActionW'($urandom);
        req_bus.row_index <= IndexW'($urandom);
        req_bus.col_index <= IndexW'($urandom);
        req_bus.cost      <= CostW'($urandom);
      end
    end
  end

  // receiver: random back-pressure plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (recv_stall_left > 0) begin
      pick_bus.ready <= 1'b0;
      recv_stall_left--;
    end else begin
      pick_bus.ready <= !(idle_on && $urandom_range(99) < 25);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == REG_SIZE) cfg_size = data[SizeW-1:0];
    else cfg_mode = data[ModeW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CostW-1:0] rand_cost();
    case ($urandom_range(3))
      0: return CostW'($urandom_range(3));
      1: return $urandom_range(1) ? '1 : '0;
      default: return CostW'($urandom);
    endcase
  endfunction

  task automatic push_load(int r, int c, logic [CostW-1:0] v);
    request_queue.push_back('{action: ACT_LOAD, row: IndexW'(r), col: IndexW'(c), cost: v});
    entry_written[r][c] = 1'b1;
    item_count++;
  endtask

  // a start only after every entry that the run reads is loaded
  task automatic push_start();
    int n;
    n = eff_size();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!entry_written[r][c]) push_load(r, c, rand_cost());
    request_queue.push_back('{action: ACT_START, row: IndexW'($urandom),
                              col: IndexW'($urandom), cost: CostW'($urandom)});
    item_count++;
  endtask

  // drain everything, then give a start with no result time to finish
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (request_queue.size() != 0 || expected_picks.size() != 0);
    repeat (Tail) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int phase;
    int n;
    int runs;
    int loads;
    logic [SizeW-1:0] sz;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_SIZE;
    cfg_data_i      = '0;
    req_bus.valid     = 1'b0;
    req_bus.action    = ACT_LOAD;
    req_bus.row_index = '0;
    req_bus.col_index = '0;
    req_bus.cost      = '0;
    pick_bus.ready  = 1'b0;
    entry_written   = '{default: '{default: 1'b0}};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single agent, top cost, mode write with upper bits set
    write_reg(REG_SIZE, 5'd1);
    write_reg(REG_MODE, 5'b11110);
    push_load(0, 0, 16'hFFFF);
    push_start();
    wait_quiet();

    // empty run gives no result
    write_reg(REG_SIZE, 5'd0);
    push_start();
    wait_quiet();

    // ties, then column mode reading the column's own entries
    write_reg(REG_SIZE, 5'd2);
    write_reg(REG_MODE, 5'b00001);
    push_load(0, 0, 16'd5);
    push_load(0, 1, 16'd5);
    push_load(1, 0, 16'd5);
    push_load(1, 1, 16'd5);
    push_start();
    push_load(1, 0, 16'd0);
    push_start();
    push_load(15, 0, 16'h8000);
    push_load(0, 15, 16'h0001);
    push_load(15, 15, 16'hFFFF);
    wait_quiet();
    write_reg(REG_MODE, {4'b0000, MODE_ROWS});
    push_start();
    wait_quiet();

    // random phases: new settings, then a few load-and-start sequences
    phase = 0;
    while (item_count < 420) begin
      case ($urandom_range(99)) inside
        [0:7]:   sz = 5'd0;
        [8:17]:  sz = 5'd16;
        [18:25]: sz = SizeW'($urandom_range(17, 31));
        default: sz = SizeW'($urandom_range(1, 6));
      endcase
      // first phase fills the whole matrix at full size
      if (phase == 0) sz = 5'd16;
      if (phase == 2) sz = SizeW'($urandom_range(4, 6));
      write_reg(REG_SIZE, sz);
      write_reg(REG_MODE, CfgDataW'($urandom));
      idle_on = !(phase >= 4 && phase < 8);
      if (phase == 2) recv_stall_left = 1500;
      n = eff_size();
      runs = (phase == 2) ? 4 : $urandom_range(1, 3);
      repeat (runs) begin
        loads = $urandom_range(0, 6);
        repeat (loads) begin
          if (n == 0 || $urandom_range(9) == 0)
            push_load($urandom_range(MaxN - 1), $urandom_range(MaxN - 1), rand_cost());
          else
            push_load($urandom_range(n - 1), $urandom_range(n - 1), rand_cost());
        end
        push_start();
      end
      wait_quiet();
      phase++;
    end

    if (error_count == 0 && expected_picks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
